// ===== sv/ahdd_pkg.sv =====
package ahdd_pkg;

   localparam int SAMPLES_PER_BURST = 8;
   localparam int AVG_SHIFT         = 3;
   localparam int SAMPLE_W          = 12;
   localparam int SUM_W             = SAMPLE_W + $clog2(SAMPLES_PER_BURST);
   localparam int TIME_W            = 32;
   localparam int THRESH_W          = 12;
   localparam int BAND_W            = 11;
   localparam int MS_W              = 16;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 16;

   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = THRESH_W'(2048);
   localparam logic [BAND_W-1:0]   BAND_RESET      = BAND_W'(50);
   localparam logic [MS_W-1:0]     DEBOUNCE_RESET  = MS_W'(100);
   localparam logic [MS_W-1:0]     INTERVAL_RESET  = MS_W'(50);

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_OPENED = 2'd1,
      EV_CLOSED = 2'd2
   } event_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LEVEL_THRESHOLD    = 2'd0,
      REG_HYSTERESIS_BAND    = 2'd1,
      REG_DEBOUNCE_MS        = 2'd2,
      REG_SAMPLE_INTERVAL_MS = 2'd3
   } reg_index_type;

   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [TIME_W-1:0]                    now_ms;
      sample_type [SAMPLES_PER_BURST-1:0]   samples;
   } item_type;

   typedef struct packed {
      logic [THRESH_W-1:0] level_threshold;
      logic [BAND_W-1:0]   hysteresis_band;
      logic [MS_W-1:0]     debounce_ms;
      logic [MS_W-1:0]     sample_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic              started;
      logic              open_level;
      logic [TIME_W-1:0] last_eval_ms;
      sample_type        held_average;
      logic              change_pending;
      logic              pending_level;
      logic [TIME_W-1:0] pending_since_ms;
   } state_type;

   typedef struct packed {
      sample_type averaged_value;
      logic       level_open;
      event_type  edge_event;
      logic       evaluated;
   } result_type;

endpackage

// ===== sv/ahdd_if.sv =====
interface ahdd_req_if
   import ahdd_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   now_ms;
   logic [SAMPLE_W-1:0] sample_0;
   logic [SAMPLE_W-1:0] sample_1;
   logic [SAMPLE_W-1:0] sample_2;
   logic [SAMPLE_W-1:0] sample_3;
   logic [SAMPLE_W-1:0] sample_4;
   logic [SAMPLE_W-1:0] sample_5;
   logic [SAMPLE_W-1:0] sample_6;
   logic [SAMPLE_W-1:0] sample_7;

   modport source (output valid, now_ms, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, input ready);
   modport sink   (input valid, now_ms, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface ahdd_rsp_if
   import ahdd_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] averaged_value;
   logic                level_open;
   logic [1:0]          edge_event;
   logic                evaluated;

   modport source (output valid, averaged_value, level_open, edge_event, evaluated,
                   input ready);
   modport sink   (input valid, averaged_value, level_open, edge_event, evaluated,
                   output ready);
endinterface

interface ahdd_csr_if
   import ahdd_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/ahdd_eval.sv =====
module ahdd_eval
   import ahdd_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  state,
   input  item_type   item,
   output state_type  state_next,
   output result_type result
);

   always_comb begin
      logic [SUM_W-1:0]      sum;
      sample_type            avg;
      logic [THRESH_W-1:0]   band_ext;
      logic [THRESH_W-1:0]   lo;
      logic [THRESH_W:0]     hi_wide;
      logic [THRESH_W-1:0]   hi;
      logic                  gate_open;
      logic                  debounce_done;
      logic                  want_open;
      logic                  in_band;
      event_type             ev;
      logic                  evaluated;

      sum = '0;
      for (int k = 0; k < SAMPLES_PER_BURST; k++) begin
         sum = sum + SUM_W'(item.samples[k]);
      end
      avg = SAMPLE_W'(sum >> AVG_SHIFT);

      band_ext = THRESH_W'(cfg.hysteresis_band);
      lo       = (cfg.level_threshold > band_ext) ? cfg.level_threshold - band_ext : '0;
      hi_wide  = {1'b0, cfg.level_threshold} + {1'b0, band_ext};
      hi       = hi_wide[THRESH_W] ? '1 : hi_wide[THRESH_W-1:0];

      gate_open     = (item.now_ms - state.last_eval_ms) >=
                      TIME_W'(cfg.sample_interval_ms);
      debounce_done = (item.now_ms - state.pending_since_ms) >=
                      TIME_W'(cfg.debounce_ms);

      want_open = 1'b0;
      in_band   = 1'b0;
      if (avg < lo) begin
         want_open = 1'b1;
      end else if (avg > hi) begin
         want_open = 1'b0;
      end else begin
         in_band = 1'b1;
      end

      state_next = state;
      ev         = EV_NONE;
      evaluated  = 1'b0;

      if (!state.started) begin
         state_next.started      = 1'b1;
         state_next.held_average = avg;
         state_next.open_level   = avg < cfg.level_threshold;
      end else if (gate_open) begin
         evaluated               = 1'b1;
         state_next.last_eval_ms = item.now_ms;
         state_next.held_average = avg;
         if (in_band || want_open == state.open_level) begin
            state_next.change_pending = 1'b0;
         end else if (!state.change_pending || state.pending_level != want_open) begin
            state_next.change_pending   = 1'b1;
            state_next.pending_level    = want_open;
            state_next.pending_since_ms = item.now_ms;
         end else if (debounce_done) begin
            state_next.change_pending = 1'b0;
            state_next.open_level     = want_open;
            ev                        = want_open ? EV_OPENED : EV_CLOSED;
         end
      end

      result.averaged_value = state_next.held_average;
      result.level_open     = state_next.open_level;
      result.edge_event     = ev;
      result.evaluated      = evaluated;
   end

endmodule

// ===== sv/averaged_hysteresis_debounce_detector.sv =====
// datapath: an accepted request sits in the input register, then its result is loaded
//   into the result register, which drives rsp.valid
// throughput: one request per cycle while results drain; the averaging adder tree,
//   bound compares and debounce update sit in a single stage between those registers
// reset: synchronous, active high; clears both stage valids, the detector state and
//   loads the register defaults (threshold 2048, band 50, debounce 100, interval 50)
module averaged_hysteresis_debounce_detector
   import ahdd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   ahdd_req_if.sink   req,
   ahdd_rsp_if.source rsp,
   ahdd_csr_if.sink   csr
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   item_type   item_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       out_valid_ff;
   result_type result_ff;
   result_type result_in;
   logic       advance;
   logic       req_fire;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_threshold    <= THRESHOLD_RESET;
         cfg_ff.hysteresis_band    <= BAND_RESET;
         cfg_ff.debounce_ms        <= DEBOUNCE_RESET;
         cfg_ff.sample_interval_ms <= INTERVAL_RESET;
      end else if (csr.valid && csr.ready) begin
         unique case (reg_index_type'(csr.index))
            REG_LEVEL_THRESHOLD:    cfg_ff.level_threshold    <= THRESH_W'(csr.data);
            REG_HYSTERESIS_BAND:    cfg_ff.hysteresis_band    <= BAND_W'(csr.data);
            REG_DEBOUNCE_MS:        cfg_ff.debounce_ms        <= MS_W'(csr.data);
            REG_SAMPLE_INTERVAL_MS: cfg_ff.sample_interval_ms <= MS_W'(csr.data);
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.now_ms     <= req.now_ms;
         item_ff.samples[0] <= req.sample_0;
         item_ff.samples[1] <= req.sample_1;
         item_ff.samples[2] <= req.sample_2;
         item_ff.samples[3] <= req.sample_3;
         item_ff.samples[4] <= req.sample_4;
         item_ff.samples[5] <= req.sample_5;
         item_ff.samples[6] <= req.sample_6;
         item_ff.samples[7] <= req.sample_7;
      end
   end

   ahdd_eval u_eval (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.averaged_value = result_ff.averaged_value;
   assign rsp.level_open     = result_ff.level_open;
   assign rsp.edge_event     = result_ff.edge_event;
   assign rsp.evaluated      = result_ff.evaluated;

endmodule

// ===== sv/ahdd_checker.sv =====
module ahdd_checker
   import ahdd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SAMPLE_W-1:0] rsp_averaged_value,
   input logic                rsp_level_open,
   input logic [1:0]          rsp_edge_event,
   input logic                rsp_evaluated
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_averaged_value)
         && $stable(rsp_level_open) && $stable(rsp_edge_event) && $stable(rsp_evaluated))
      else $error("response changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_event_needs_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_edge_event != EV_NONE |-> rsp_evaluated)
      else $error("event without evaluation");

   a_event_matches_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_edge_event != EV_NONE |->
         (rsp_edge_event == EV_OPENED && rsp_level_open)
         || (rsp_edge_event == EV_CLOSED && !rsp_level_open))
      else $error("event disagrees with level");

endmodule

bind averaged_hysteresis_debounce_detector ahdd_checker u_ahdd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_averaged_value (rsp.averaged_value),
   .rsp_level_open     (rsp.level_open),
   .rsp_edge_event     (rsp.edge_event),
   .rsp_evaluated      (rsp.evaluated)
);

// ===== tb/sv/ahdd_detector_checker.sv =====
`timescale 1ns / 1ps
module ahdd_detector_checker
   import ahdd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ahdd_req_if  req,
   ahdd_rsp_if  rsp,
   ahdd_csr_if  csr,
   output int   fail_count,
   output int   results_outstanding
);

   cfg_type    settings;
   state_type  detector;
   result_type expected_results [$];

   initial begin
      fail_count = 0;
      results_outstanding = 0;
   end

   task automatic flag_error(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic sample_type burst_mean(input item_type it);
      logic [SUM_W-1:0] total;
      int               k;
      total = '0;
      for (k = 0; k < SAMPLES_PER_BURST; k++) begin
         total += SUM_W'(it.samples[k]);
      end
      return sample_type'(total >> AVG_SHIFT);
   endfunction

   function automatic result_type step_detector(input item_type it);
      result_type        res;
      sample_type        mean;
      logic [THRESH_W:0] low_bound;
      logic [THRESH_W:0] high_bound;
      logic [TIME_W-1:0] since_eval;
      logic [TIME_W-1:0] since_pending;
      logic              want_open;
      logic              dead_zone;
      res.edge_event = EV_NONE;
      res.evaluated  = 1'b0;
      since_eval     = it.now_ms - detector.last_eval_ms;
      if (!detector.started) begin
         detector.held_average = burst_mean(it);
         detector.open_level   = detector.held_average < settings.level_threshold;
         detector.started      = 1'b1;
      end else if (since_eval >= TIME_W'(settings.sample_interval_ms)) begin
         res.evaluated         = 1'b1;
         detector.last_eval_ms = it.now_ms;
         mean                  = burst_mean(it);
         detector.held_average = mean;
         low_bound  = (settings.level_threshold > settings.hysteresis_band) ?
                      settings.level_threshold - settings.hysteresis_band : '0;
         high_bound = settings.level_threshold + settings.hysteresis_band;
         if (high_bound > 4095) begin
            high_bound = 4095;
         end
         dead_zone = 1'b0;
         want_open = 1'b0;
         if (mean < low_bound) begin
            want_open = 1'b1;
         end else if (mean <= high_bound) begin
            dead_zone = 1'b1;
         end
         since_pending = it.now_ms - detector.pending_since_ms;
         if (dead_zone || want_open == detector.open_level) begin
            detector.change_pending = 1'b0;
         end else if (!detector.change_pending || detector.pending_level != want_open) begin
            detector.change_pending   = 1'b1;
            detector.pending_level    = want_open;
            detector.pending_since_ms = it.now_ms;
         end else if (since_pending >= TIME_W'(settings.debounce_ms)) begin
            detector.change_pending = 1'b0;
            detector.open_level     = want_open;
            res.edge_event          = want_open ? EV_OPENED : EV_CLOSED;
         end
      end
      res.averaged_value = detector.held_average;
      res.level_open     = detector.open_level;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      item_type   incoming;
      result_type want;
      if (reset) begin
         settings = '{THRESHOLD_RESET, BAND_RESET, DEBOUNCE_RESET, INTERVAL_RESET};
         detector = '0;
         expected_results.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               flag_error("result with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               if (rsp.averaged_value !== want.averaged_value) begin
                  flag_error($sformatf("averaged_value got %0d want %0d",
                                       rsp.averaged_value, want.averaged_value));
               end
               if (rsp.level_open !== want.level_open) begin
                  flag_error($sformatf("level_open got %0d want %0d",
                                       rsp.level_open, want.level_open));
               end
               if (rsp.edge_event !== want.edge_event) begin
                  flag_error($sformatf("edge_event got %0d want %0d",
                                       rsp.edge_event, want.edge_event));
               end
               if (rsp.evaluated !== want.evaluated) begin
                  flag_error($sformatf("evaluated got %0d want %0d",
                                       rsp.evaluated, want.evaluated));
               end
            end
         end
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_LEVEL_THRESHOLD:    settings.level_threshold    = csr.data[THRESH_W-1:0];
               REG_HYSTERESIS_BAND:    settings.hysteresis_band    = csr.data[BAND_W-1:0];
               REG_DEBOUNCE_MS:        settings.debounce_ms        = csr.data[MS_W-1:0];
               REG_SAMPLE_INTERVAL_MS: settings.sample_interval_ms = csr.data[MS_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            incoming.now_ms     = req.now_ms;
            incoming.samples[0] = req.sample_0;
            incoming.samples[1] = req.sample_1;
            incoming.samples[2] = req.sample_2;
            incoming.samples[3] = req.sample_3;
            incoming.samples[4] = req.sample_4;
            incoming.samples[5] = req.sample_5;
            incoming.samples[6] = req.sample_6;
            incoming.samples[7] = req.sample_7;
            expected_results.push_back(step_detector(incoming));
         end
      end
      results_outstanding = expected_results.size();
   end

endmodule

// ===== tb/sv/tb_averaged_hysteresis_debounce_detector.sv =====
`timescale 1ns / 1ps
module tb_averaged_hysteresis_debounce_detector;
   import ahdd_pkg::*;

   typedef enum int {
      ZONE_OPEN,
      ZONE_CLOSED,
      ZONE_DEAD
   } zone_kind;

   logic clock;
   logic reset;
   int   fail_count;
   int   results_outstanding;
   bit   fast_mode;
   int   long_holds_asked;
   int   no_gap_items;

   logic [THRESH_W-1:0] cur_threshold;
   logic [BAND_W-1:0]   cur_band;
   logic [MS_W-1:0]     cur_debounce;
   logic [MS_W-1:0]     cur_interval;
   logic [TIME_W-1:0]   timeline_ms;
   zone_kind            zone;

   ahdd_req_if req_bus ();
   ahdd_rsp_if rsp_bus ();
   ahdd_csr_if csr_bus ();

   averaged_hysteresis_debounce_detector dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   ahdd_detector_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req                 (req_bus),
      .rsp                 (rsp_bus),
      .csr                 (csr_bus),
      .fail_count          (fail_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic item_type flat_burst(input logic [TIME_W-1:0] stamp,
                                           input sample_type level);
      item_type it;
      it.now_ms  = stamp;
      it.samples = {SAMPLES_PER_BURST{level}};
      return it;
   endfunction

   task automatic offer_item(input item_type it);
      int gap;
      if (fast_mode || no_gap_items > 0) begin
         gap = 0;
      end else begin
         gap = $urandom_range(0, 19);
      end
      if (no_gap_items > 0) begin
         no_gap_items--;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.now_ms   <= it.now_ms;
      req_bus.sample_0 <= it.samples[0];
      req_bus.sample_1 <= it.samples[1];
      req_bus.sample_2 <= it.samples[2];
      req_bus.sample_3 <= it.samples[3];
      req_bus.sample_4 <= it.samples[4];
      req_bus.sample_5 <= it.samples[5];
      req_bus.sample_6 <= it.samples[6];
      req_bus.sample_7 <= it.samples[7];
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (results_outstanding != 0) @(negedge clock);
   endtask

   // upper data bits beyond the register width are random
   task automatic load_settings();
      reg_index_type         order [4];
      logic [CSR_DATA_W-1:0] words [4];
      int                    i;
      order = '{REG_LEVEL_THRESHOLD, REG_HYSTERESIS_BAND, REG_DEBOUNCE_MS,
                REG_SAMPLE_INTERVAL_MS};
      words = '{{4'($urandom), cur_threshold}, {5'($urandom), cur_band},
                cur_debounce, cur_interval};
      for (i = 0; i < 4; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= order[i];
         csr_bus.data  <= words[i];
         do @(posedge clock); while (!csr_bus.ready);
         @(negedge clock);
      end
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_random_item();
      item_type          it;
      logic [THRESH_W:0] low_bound;
      logic [THRESH_W:0] high_bound;
      logic [TIME_W-1:0] step;
      int                span_lo;
      int                span_hi;
      int                target;
      int                spread;
      int                partial;
      int                sample;
      int                k;
      low_bound  = (cur_threshold > cur_band) ? cur_threshold - cur_band : '0;
      high_bound = cur_threshold + cur_band;
      if (high_bound > 4095) begin
         high_bound = 4095;
      end
      if ($urandom_range(0, 99) < 8) begin
         it.now_ms = $urandom;
         for (k = 0; k < SAMPLES_PER_BURST; k++) begin
            it.samples[k] = sample_type'($urandom);
         end
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            zone = zone_kind'($urandom_range(0, 2));
         end
         span_lo = int'(low_bound);
         span_hi = int'(high_bound);
         if (zone == ZONE_OPEN && low_bound > 0) begin
            span_lo = 0;
            span_hi = int'(low_bound) - 1;
         end else if (zone == ZONE_CLOSED && high_bound < 4095) begin
            span_lo = int'(high_bound) + 1;
            span_hi = 4095;
         end
         if ($urandom_range(0, 3) == 0) begin
            target = $urandom_range(0, 1) ? span_lo : span_hi;
         end else begin
            target = int'($urandom_range(span_lo, span_hi));
         end
         if ($urandom_range(0, 1)) begin
            it.samples = {SAMPLES_PER_BURST{sample_type'(target)}};
         end else begin
            spread  = int'($urandom_range(1, 600));
            partial = 0;
            for (k = 0; k < SAMPLES_PER_BURST - 1; k++) begin
               sample = target + int'($urandom_range(0, 2 * spread)) - spread;
               sample = (sample < 0) ? 0 : (sample > 4095) ? 4095 : sample;
               it.samples[k] = sample_type'(sample);
               partial += sample;
            end
            sample = 8 * target + int'($urandom_range(0, 7)) - partial;
            sample = (sample < 0) ? 0 : (sample > 4095) ? 4095 : sample;
            it.samples[SAMPLES_PER_BURST-1] = sample_type'(sample);
         end
         case ($urandom_range(0, 9))
            0:       step = '0;
            1:       step = TIME_W'(cur_interval) - 1;
            2, 3:    step = TIME_W'(cur_interval);
            4, 5, 6: step = TIME_W'(cur_interval) + $urandom_range(0, cur_interval);
            7:       step = TIME_W'(cur_debounce);
            8:       step = $urandom_range(0, 32'(cur_debounce) + 32'(cur_interval));
            default: step = $urandom;
         endcase
         timeline_ms += step;
         it.now_ms = timeline_ms;
      end
      offer_item(it);
   endtask

   initial begin : response_drain
      int hold;
      int long_holds_done;
      rsp_bus.ready <= 1'b0;
      long_holds_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_holds_done != long_holds_asked) begin
            long_holds_done++;
            hold = 300;
         end else if (fast_mode) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 19);
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      item_type it;
      int       phase;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.now_ms   <= '0;
      req_bus.sample_0 <= '0;
      req_bus.sample_1 <= '0;
      req_bus.sample_2 <= '0;
      req_bus.sample_3 <= '0;
      req_bus.sample_4 <= '0;
      req_bus.sample_5 <= '0;
      req_bus.sample_6 <= '0;
      req_bus.sample_7 <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= REG_LEVEL_THRESHOLD;
      csr_bus.data     <= '0;
      fast_mode        = 1'b0;
      long_holds_asked = 0;
      no_gap_items     = 0;
      cur_threshold    = THRESHOLD_RESET;
      cur_band         = BAND_RESET;
      cur_debounce     = DEBOUNCE_RESET;
      cur_interval     = INTERVAL_RESET;
      zone             = ZONE_DEAD;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: low bound 1998, high bound 2098
      offer_item(flat_burst(32'd10, 12'd4095));
      offer_item(flat_burst(32'd20, 12'd0));
      offer_item(flat_burst(32'd50, 12'd0));
      offer_item(flat_burst(32'd99, 12'd0));
      offer_item(flat_burst(32'd100, 12'd0));
      offer_item(flat_burst(32'd150, 12'd1997));
      offer_item(flat_burst(32'd200, 12'd1998));
      offer_item(flat_burst(32'd250, 12'd2098));
      offer_item(flat_burst(32'd300, 12'd2099));
      offer_item(flat_burst(32'd350, 12'd1998));
      offer_item(flat_burst(32'd400, 12'd2099));
      offer_item(flat_burst(32'd450, 12'd0));
      offer_item(flat_burst(32'd500, 12'd4095));
      offer_item(flat_burst(32'd550, 12'd4095));
      offer_item(flat_burst(32'd600, 12'd4095));
      it = flat_burst(32'd650, 12'd0);
      it.samples[1] = 12'd4095;
      it.samples[3] = 12'd4095;
      it.samples[5] = 12'd4095;
      it.samples[7] = 12'd4095;
      offer_item(it);
      // timestamps wrap around zero
      offer_item(flat_burst(32'hFFFF_FFF0, 12'd0));
      offer_item(flat_burst(32'h0000_0060, 12'd0));
      offer_item(flat_burst(32'h0000_0050, 12'd4095));
      it = flat_burst(32'h0000_00A0, 12'd4095);
      it.samples[7] = 12'd4088;
      offer_item(it);
      timeline_ms = 32'h0000_00A0;

      for (phase = 0; phase < 12; phase++) begin
         wait_until_drained();
         case (phase)
            0: begin
               cur_threshold = '0;
               cur_band      = '0;
               cur_debounce  = '0;
               cur_interval  = '0;
            end
            1: begin
               cur_threshold = 12'd4095;
               cur_band      = 11'd2047;
               cur_debounce  = 16'd65535;
               cur_interval  = 16'd65535;
            end
            2: begin
               cur_threshold = 12'd2047;
               cur_band      = '0;
               cur_debounce  = '0;
               cur_interval  = 16'd1;
            end
            3: begin
               cur_threshold = 12'd1000;
               cur_band      = 11'd2047;
               cur_debounce  = 16'd7;
               cur_interval  = 16'd3;
            end
            default: begin
               cur_threshold = THRESH_W'($urandom_range(0, 4095));
               cur_band      = ($urandom_range(0, 3) == 0) ?
                               BAND_W'($urandom_range(0, 2047)) :
                               BAND_W'($urandom_range(0, 300));
               cur_debounce  = MS_W'($urandom_range(0, 600));
               cur_interval  = MS_W'($urandom_range(0, 150));
            end
         endcase
         load_settings();
         fast_mode = (phase % 4 == 2);
         // response side holds off while requests keep coming
         if (phase == 5 || phase == 9) begin
            long_holds_asked++;
            no_gap_items = 40;
         end
         repeat (140) send_random_item();
      end

      wait_until_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
